@@ src/bls_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bls_pkg: shared types and constants of the block-linear swizzle blitter
// Surface geometry, swizzle masks, register map and the configuration bundle.
// ----------------------------------------------------------------------------
package bls_pkg;

  // Surface geometry
  localparam int unsigned PaddedWidth = 1280;
  localparam int unsigned AddrBits    = 22;
  localparam int unsigned WordBits    = 22;
  localparam int unsigned TileLines   = 128;
  localparam int unsigned TileShift   = $clog2(TileLines);

  typedef logic [AddrBits-1:0] addr_t;

  // y lands on the bits of YMaskFull, x on all the others
  localparam logic [31:0] YMaskFull = 32'h0000_07B4;
  localparam logic [31:0] XMaskFull = ~YMaskFull;
  localparam logic [10:0] YMask     = YMaskFull[10:0];
  localparam addr_t       XMask     = XMaskFull[AddrBits-1:0];

  localparam logic [31:0] AlphaMask = 32'hFF00_0000;
  localparam logic [31:0] ColorMask = 32'h00FF_FFFF;

  // Register map (index = paddr / 4)
  localparam int unsigned PaddrBits = 5;
  localparam logic [2:0] RegRectWidth  = 3'd0;
  localparam logic [2:0] RegRectHeight = 3'd1;
  localparam logic [2:0] RegOriginX    = 3'd2;
  localparam logic [2:0] RegOriginY    = 3'd3;
  localparam logic [2:0] RegBlendEn    = 3'd4;

  localparam logic [11:0] RectWidthRst  = 12'd1280;
  localparam logic [11:0] RectHeightRst = 12'd720;

  // Scatter the bits of v over the set bits of mask, lowest first
  function automatic logic [31:0] deposit(logic [31:0] mask, logic [31:0] v);
    logic [31:0] r;
    logic [31:0] s;
    r = '0;
    s = v;
    for (int k = 0; k < 32; k++) begin
      if (mask[k]) begin
        r[k] = s[0];
        s    = s >> 1;
      end
    end
    return r;
  endfunction

  // Offset of one tile row further down the surface
  localparam logic [31:0] TileRowStepFull = deposit(XMaskFull, 32'(PaddedWidth));
  localparam addr_t       TileRowStep     = TileRowStepFull[AddrBits-1:0];

  typedef struct packed {
    logic [11:0] rect_width;
    logic [11:0] rect_height;
    logic [11:0] origin_x;
    logic [11:0] origin_y;
    logic        blend_enable;
    logic        restart;      // one-cycle pulse on any register write
  } cfg_t;

endpackage

@@ src/block_linear_swizzle_blit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_linear_swizzle_blit: block-linear swizzle blitter
// Turns a raster stream of source pixels into tiled framebuffer writes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid_i / in_stall_o carry one source pixel per item,
//   in raster order over the rectangle set by the registers.
//   Output channel: out_valid_o / out_stall_i carry one write per item:
//   word address, data, write enable and a flag on the final pixel.
//   The output is registered: an accepted item appears at the output register
//   in the cycle after it is accepted. The output register is refilled in the
//   cycle its item is taken, so one item is taken every cycle and throughput is
//   one pixel per clock while the receiver does not stall.
//   When the receiver stalls, the result is held and in_stall_o is raised
//   until it is taken.
//   Reset loads the default rectangle (1280 x 720 at the origin, no blending)
//   and empties the output register. Any register write, and the end of the
//   rectangle, restarts the walk at the rectangle's first pixel.
//   Registers sit at byte addresses 0, 4, 8, 12, 16 of the APB port.
// ----------------------------------------------------------------------------
module block_linear_swizzle_blit
  import bls_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PaddrBits-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [31:0]          source_pixel_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [WordBits-1:0]  word_address_o,
  output logic [31:0]          write_data_o,
  output logic                 write_enable_o,
  output logic                 last_pixel_o
);

  cfg_t                cfg;
  logic                accept;
  logic [WordBits-1:0] addr;
  logic                last;
  logic [31:0]         data;
  logic                we;

  logic                out_valid_q, out_valid_d;
  logic [WordBits-1:0] addr_q;
  logic [31:0]         data_q;
  logic                we_q, last_q;

  bls_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  bls_addr_gen u_addr_gen (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .advance_i      (accept),
    .word_address_o (addr),
    .last_pixel_o   (last)
  );

  // Blend (when enabled): transparent pixels are dropped, others lose their alpha byte
  always_comb begin
    data = source_pixel_i;
    we   = 1'b1;
    if (cfg.blend_enable) begin
      if ((source_pixel_i & AlphaMask) == '0) begin
        we   = 1'b0;
        data = '0;
      end else begin
        data = source_pixel_i & ColorMask;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      addr_q <= addr;
      data_q <= data;
      we_q   <= we;
      last_q <= last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign word_address_o = addr_q;
  assign write_data_o   = data_q;
  assign write_enable_o = we_q;
  assign last_pixel_o   = last_q;

endmodule

@@ src/bls_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bls_cfg: configuration registers
// APB-style register file for rectangle size, origin and blend mode.
// ----------------------------------------------------------------------------
module bls_cfg
  import bls_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PaddrBits-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  output cfg_t                 cfg_o
);

  logic [11:0] rect_width_q, rect_height_q, origin_x_q, origin_y_q;
  logic        blend_enable_q;
  logic        restart_q;
  logic        wr_en;
  logic [2:0]  reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[PaddrBits-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rect_width_q   <= RectWidthRst;
      rect_height_q  <= RectHeightRst;
      origin_x_q     <= '0;
      origin_y_q     <= '0;
      blend_enable_q <= 1'b0;
      restart_q      <= 1'b0;
    end else begin
      restart_q <= 1'b0;
      if (wr_en) begin
        unique case (reg_idx)
          RegRectWidth: begin
            rect_width_q <= pwdata[11:0];
            restart_q    <= 1'b1;
          end
          RegRectHeight: begin
            rect_height_q <= pwdata[11:0];
            restart_q     <= 1'b1;
          end
          RegOriginX: begin
            origin_x_q <= pwdata[11:0];
            restart_q  <= 1'b1;
          end
          RegOriginY: begin
            origin_y_q <= pwdata[11:0];
            restart_q  <= 1'b1;
          end
          RegBlendEn: begin
            blend_enable_q <= pwdata[0];
            restart_q      <= 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegRectWidth:  prdata = {20'd0, rect_width_q};
      RegRectHeight: prdata = {20'd0, rect_height_q};
      RegOriginX:    prdata = {20'd0, origin_x_q};
      RegOriginY:    prdata = {20'd0, origin_y_q};
      RegBlendEn:    prdata = {31'd0, blend_enable_q};
      default:       prdata = '0;
    endcase
  end

  assign cfg_o = '{
    rect_width:   rect_width_q,
    rect_height:  rect_height_q,
    origin_x:     origin_x_q,
    origin_y:     origin_y_q,
    blend_enable: blend_enable_q,
    restart:      restart_q
  };

endmodule

@@ src/bls_addr_gen.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bls_addr_gen: tiled address walker
// Holds the swizzled x/y offsets and raster counters, advancing once per item.
// ----------------------------------------------------------------------------
module bls_addr_gen
  import bls_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfg_t                cfg_i,
  input  logic                advance_i,
  output logic [WordBits-1:0] word_address_o,
  output logic                last_pixel_o
);

  addr_t       col_off_q, row_start_q;
  logic [10:0] row_off_q;
  logic [11:0] col_cnt_q, row_cnt_q;
  logic        pending_q;   // state must be reloaded from the origin

  addr_t       col_off_d, row_start_d;
  logic [10:0] row_off_d;
  logic [11:0] col_cnt_d, row_cnt_d;
  logic        pending_d;

  logic [18:0] dep_x;
  logic [10:0] dep_y;
  logic [4:0]  tile_row;
  addr_t       base;

  logic        reload;
  addr_t       cur_col, cur_row_start;
  logic [10:0] cur_row;
  logic [11:0] cur_col_cnt, cur_row_cnt;
  addr_t       addr;
  logic [31:0] addr_ext;
  logic [10:0] row_next;
  addr_t       row_start_next;
  logic        col_more, row_more;

  // Spread origin_x over the x bits and origin_y over the y bits
  assign dep_x = {cfg_i.origin_x[11:4], 4'b0, cfg_i.origin_x[3], 2'b0,
                  cfg_i.origin_x[2], 1'b0, cfg_i.origin_x[1:0]};
  assign dep_y = {cfg_i.origin_y[6:3], 1'b0, cfg_i.origin_y[2:1], 1'b0,
                  cfg_i.origin_y[0], 2'b0};
  assign tile_row = cfg_i.origin_y[11:TileShift];
  assign base     = addr_t'(dep_x) + addr_t'(TileRowStep * addr_t'(tile_row));

  // A register write in the previous cycle restarts the walk for this item too
  assign reload = pending_q | cfg_i.restart;

  assign cur_col       = reload ? base  : col_off_q;
  assign cur_row_start = reload ? base  : row_start_q;
  assign cur_row       = reload ? dep_y : row_off_q;
  assign cur_col_cnt   = reload ? '0    : col_cnt_q;
  assign cur_row_cnt   = reload ? '0    : row_cnt_q;

  assign addr     = addr_t'(cur_row) + cur_col;
  assign addr_ext = 32'(addr);
  assign word_address_o = addr_ext[WordBits-1:0];

  assign col_more = (13'(cur_col_cnt) + 13'd1) < 13'(cfg_i.rect_width);
  assign row_more = (13'(cur_row_cnt) + 13'd1) < 13'(cfg_i.rect_height);

  // Subtracting the mask and masking again increments the offset within its bit set
  assign row_next       = (cur_row - YMask) & YMask;
  assign row_start_next = (row_next == '0) ? cur_row_start + TileRowStep
                                           : cur_row_start;

  assign last_pixel_o = !col_more && !row_more;

  always_comb begin
    col_off_d   = col_off_q;
    row_start_d = row_start_q;
    row_off_d   = row_off_q;
    col_cnt_d   = col_cnt_q;
    row_cnt_d   = row_cnt_q;
    pending_d   = reload;
    if (advance_i) begin
      pending_d = 1'b0;
      if (col_more) begin
        col_cnt_d   = cur_col_cnt + 12'd1;
        col_off_d   = (cur_col - XMask) & XMask;
        row_start_d = cur_row_start;
        row_off_d   = cur_row;
        row_cnt_d   = cur_row_cnt;
      end else begin
        col_cnt_d   = '0;
        row_off_d   = row_next;
        row_start_d = row_start_next;
        col_off_d   = row_start_next;
        row_cnt_d   = cur_row_cnt + 12'd1;
        // end of rectangle: reload from the origin on the next item
        pending_d   = !row_more;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b1;
    end else begin
      pending_q <= pending_d;
    end
  end

  always_ff @(posedge clk_i) begin
    col_off_q   <= col_off_d;
    row_start_q <= row_start_d;
    row_off_q   <= row_off_d;
    col_cnt_q   <= col_cnt_d;
    row_cnt_q   <= row_cnt_d;
  end

endmodule
